>>> rtl/core/hmbox_pkg.sv
// Shared types and constants of the 3x3 height box filter.
// No dependencies; used by every module of the block.
package hmbox_pkg;

    localparam int MAX_COLS_DEF = 1024;
    localparam int MAX_ROWS_DEF = 4096;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;

    localparam logic [CFG_IDX_W-1:0] CFG_ROWS   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET = 2'd3;

    localparam int ROWS_REG_W   = 13;
    localparam int COLS_REG_W   = 11;
    localparam int SCALE_REG_W  = 16;
    localparam int OFFSET_REG_W = 24;

    localparam logic [ROWS_REG_W-1:0]   ROWS_RST   = 13'd4096;
    localparam logic [COLS_REG_W-1:0]   COLS_RST   = 11'd1024;
    localparam logic [SCALE_REG_W-1:0]  SCALE_RST  = 16'd256;
    localparam logic [OFFSET_REG_W-1:0] OFFSET_RST = 24'd0;

    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_FLUSH  = 1'b1;

    localparam int HEIGHT_W  = 32;
    localparam int OUT_ROW_W = 12;
    localparam int OUT_COL_W = 10;

    // window sum of nine bytes, then mean in Q.8
    localparam int SUM_W  = 12;
    localparam int MEAN_W = SUM_W + 8;

    // line store word: one byte per row slot, row taken modulo four
    localparam int LANES = 4;
    typedef logic [LANES-1:0][7:0] line_word_t;

    typedef struct packed {
        logic       cmd;
        logic [7:0] raw_height;
    } in_t;

    typedef struct packed {
        logic signed [HEIGHT_W-1:0] height;
        logic [OUT_ROW_W-1:0]       out_row;
        logic [OUT_COL_W-1:0]       out_col;
        logic                       frame_last;
    } out_t;

    typedef struct packed {
        logic             start;
        logic             ack;
        logic [SUM_W-1:0] sum;
        logic [1:0]       rdiv;
        logic [1:0]       cdiv;
    } norm_req_t;

    typedef struct packed {
        logic                       done;
        logic signed [HEIGHT_W-1:0] height;
    } norm_rsp_t;

endpackage

>>> rtl/core/hmbox_line_mem.sv
// Column-organized line store: one word per column, one byte lane per row slot.
// Byte-lane write port, two registered read ports. Uses hmbox_pkg.
module hmbox_line_mem #(
    parameter int MAX_COLS = hmbox_pkg::MAX_COLS_DEF
) (
    input  logic                        clk,
    input  logic                        we,
    input  logic [$clog2(MAX_COLS)-1:0] waddr,
    input  logic [1:0]                  wlane,
    input  logic [7:0]                  wdata,
    input  logic [$clog2(MAX_COLS)-1:0] raddr_a,
    input  logic [$clog2(MAX_COLS)-1:0] raddr_b,
    output hmbox_pkg::line_word_t       rdata_a,
    output hmbox_pkg::line_word_t       rdata_b
);

    hmbox_pkg::line_word_t mem [MAX_COLS];
    hmbox_pkg::line_word_t rd_a_reg;
    hmbox_pkg::line_word_t rd_b_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr][wlane] <= wdata;
        end
        rd_a_reg <= mem[raddr_a];
        rd_b_reg <= mem[raddr_b];
    end

    assign rdata_a = rd_a_reg;
    assign rdata_b = rd_b_reg;

endmodule

>>> rtl/core/hmbox_norm.sv
// Normalize unit: window sum to truncated Q.8 mean (divide by rows then cols),
// scale by signed Q8.8, floor, add offset. Uses hmbox_pkg.
module hmbox_norm (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  hmbox_pkg::norm_req_t                   req,
    input  logic signed [hmbox_pkg::SCALE_REG_W-1:0]  scale,
    input  logic signed [hmbox_pkg::OFFSET_REG_W-1:0] offset,
    output hmbox_pkg::norm_rsp_t                   rsp
);

    localparam int MW     = hmbox_pkg::MEAN_W;
    localparam int HW     = hmbox_pkg::HEIGHT_W;
    localparam int OW     = hmbox_pkg::OFFSET_REG_W;
    localparam int PW     = MW + 1 + hmbox_pkg::SCALE_REG_W;
    localparam int RSHIFT = MW + 1;
    localparam logic [MW-1:0] RECIP3 = MW'((2 ** RSHIFT + 2) / 3);

    localparam logic [2:0] N_IDLE = 3'd0;
    localparam logic [2:0] N_DIVR = 3'd1;
    localparam logic [2:0] N_DIVC = 3'd2;
    localparam logic [2:0] N_MUL  = 3'd3;
    localparam logic [2:0] N_DONE = 3'd4;

    logic [2:0]           st_reg, st_next;
    logic [MW-1:0]        num_reg, num_next;
    logic [1:0]           rdiv_reg, rdiv_next;
    logic [1:0]           cdiv_reg, cdiv_next;
    logic signed [PW-1:0] prod_reg, prod_next;
    logic signed [PW-1:0] shifted;

    // floor(n / d) for d in 1..3; divide by three through the reciprocal
    function automatic logic [MW-1:0] div123(input logic [MW-1:0] n, input logic [1:0] d);
        logic [2*MW-1:0] p;
        logic [MW-1:0]   q;
        p = n * RECIP3;
        case (d)
            2'd2:    q = n >> 1;
            2'd3:    q = MW'(p[2*MW-1:RSHIFT]);
            default: q = n;
        endcase
        return q;
    endfunction

    always_comb
    begin
        st_next   = st_reg;
        num_next  = num_reg;
        rdiv_next = rdiv_reg;
        cdiv_next = cdiv_reg;
        prod_next = prod_reg;
        unique case (st_reg)
            N_IDLE:
            begin
                if (req.start)
                begin
                    num_next  = {req.sum, 8'd0};
                    rdiv_next = req.rdiv;
                    cdiv_next = req.cdiv;
                    st_next   = N_DIVR;
                end
            end
            N_DIVR:
            begin
                num_next = div123(num_reg, rdiv_reg);
                st_next  = N_DIVC;
            end
            N_DIVC:
            begin
                num_next = div123(num_reg, cdiv_reg);
                st_next  = N_MUL;
            end
            N_MUL:
            begin
                prod_next = $signed({1'b0, num_reg}) * scale;
                st_next   = N_DONE;
            end
            N_DONE:
            begin
                if (req.ack)
                begin
                    st_next = N_IDLE;
                end
            end
            default:
            begin
                st_next = N_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= N_IDLE;
        end
        else
        begin
            st_reg <= st_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg  <= num_next;
        rdiv_reg <= rdiv_next;
        cdiv_reg <= cdiv_next;
        prod_reg <= prod_next;
    end

    assign shifted     = prod_reg >>> 8;
    assign rsp.done    = (st_reg == N_DONE);
    assign rsp.height  = shifted[HW-1:0] + {{(HW - OW){offset[OW-1]}}, offset};

endmodule

>>> rtl/core/heightmap_scale_box_filter_3x3_top.sv
// Top level of the 3x3 edge-normalized height box filter with scale and offset.
// Instantiates hmbox_line_mem and hmbox_norm; uses hmbox_pkg.
//
// Raw height bytes of a grid_rows by grid_cols grid enter in raster order; each
// request that completes the neighbourhood of a cell (grid_cols+1 samples later)
// yields that cell's mean over its in-bounds 3x3 neighbours, scaled by
// height_scale (Q8.8) and offset by height_offset, as signed Q.8. Flush requests
// drain the cells still pending after the last sample. A request that yields no
// result leaves the input ready for the next one; one that yields a result stalls
// the input, also while it waits for the output register: the sample is written
// at acceptance, the three neighbour columns are read from the column-organized
// line store in states RD0 to RD2, and the normalize unit spends two divide steps
// and one multiply before the result moves to the output register. The output
// register lets the next request enter while a result waits. Writing grid_rows or
// grid_cols restarts the frame.
module heightmap_scale_box_filter_3x3_top #(
    parameter int MAX_COLS = hmbox_pkg::MAX_COLS_DEF,
    parameter int MAX_ROWS = hmbox_pkg::MAX_ROWS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  hmbox_pkg::in_t                      in_data,
    output logic                                out_valid,
    input  logic                                out_stall,
    output hmbox_pkg::out_t                     out_data,
    input  logic                                cfg_we,
    input  logic [hmbox_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [hmbox_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int CW  = $clog2(MAX_COLS);
    localparam int RW  = $clog2(MAX_ROWS + 1);
    localparam int ORW = hmbox_pkg::OUT_ROW_W;
    localparam int OCW = hmbox_pkg::OUT_COL_W;
    localparam int SW  = hmbox_pkg::SUM_W;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_RD0  = 3'd1;
    localparam logic [2:0] ST_RD1  = 3'd2;
    localparam logic [2:0] ST_RD2  = 3'd3;
    localparam logic [2:0] ST_WAIT = 3'd4;

    logic [hmbox_pkg::ROWS_REG_W-1:0]   rows_reg;
    logic [hmbox_pkg::COLS_REG_W-1:0]   cols_reg;
    logic [hmbox_pkg::SCALE_REG_W-1:0]  scale_reg;
    logic [hmbox_pkg::OFFSET_REG_W-1:0] offset_reg;

    logic [2:0]    state_reg, state_next;
    logic [RW-1:0] in_row_reg, in_row_next;
    logic [CW-1:0] in_col_reg, in_col_next;
    logic [RW-1:0] out_row_reg, out_row_next;
    logic [CW-1:0] out_col_reg, out_col_next;
    logic [SW-1:0] sum_reg, sum_next;
    logic          out_valid_reg, out_valid_next;
    hmbox_pkg::out_t out_data_reg, out_data_next;

    logic [RW-1:0] nrows;
    logic [CW:0]   ncols;
    logic          accept, in_done, lag_ok, do_store, do_emit, restart, load, last;
    logic [CW:0]   in_col_p1, co_p1;
    logic [RW-1:0] ro_p1;
    logic          up_ok, dn_ok, lft_ok, rgt_ok;
    logic [1:0]    rv, cv;
    logic [CW-1:0] raddr_a, raddr_b;
    hmbox_pkg::line_word_t rdata_a, rdata_b;
    hmbox_pkg::norm_req_t  norm_req;
    hmbox_pkg::norm_rsp_t  norm_rsp;

    function automatic logic [9:0] col_sum(input hmbox_pkg::line_word_t w,
                                           input logic [1:0] lane,
                                           input logic uok, input logic dok);
        logic [1:0] lu;
        logic [1:0] ld;
        logic [9:0] s;
        lu = lane - 2'd1;
        ld = lane + 2'd1;
        s  = 10'(w[lane]);
        if (uok)
        begin
            s = s + 10'(w[lu]);
        end
        if (dok)
        begin
            s = s + 10'(w[ld]);
        end
        return s;
    endfunction

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg   <= hmbox_pkg::ROWS_RST;
            cols_reg   <= hmbox_pkg::COLS_RST;
            scale_reg  <= hmbox_pkg::SCALE_RST;
            offset_reg <= hmbox_pkg::OFFSET_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                hmbox_pkg::CFG_ROWS:   rows_reg   <= cfg_data[hmbox_pkg::ROWS_REG_W-1:0];
                hmbox_pkg::CFG_COLS:   cols_reg   <= cfg_data[hmbox_pkg::COLS_REG_W-1:0];
                hmbox_pkg::CFG_SCALE:  scale_reg  <= cfg_data[hmbox_pkg::SCALE_REG_W-1:0];
                hmbox_pkg::CFG_OFFSET: offset_reg <= cfg_data[hmbox_pkg::OFFSET_REG_W-1:0];
                default:               rows_reg   <= rows_reg;
            endcase
        end
    end

    // effective grid size, clamped
    always_comb
    begin
        if (rows_reg == '0)
        begin
            nrows = RW'(1);
        end
        else if (int'(rows_reg) > MAX_ROWS)
        begin
            nrows = RW'(MAX_ROWS);
        end
        else
        begin
            nrows = RW'(rows_reg);
        end
        if (cols_reg == '0)
        begin
            ncols = (CW + 1)'(1);
        end
        else if (int'(cols_reg) > MAX_COLS)
        begin
            ncols = (CW + 1)'(MAX_COLS);
        end
        else
        begin
            ncols = (CW + 1)'(cols_reg);
        end
    end

    assign in_stall = (state_reg != ST_IDLE);
    assign accept   = in_valid && !in_stall;
    assign in_done  = (in_row_reg >= nrows);
    assign lag_ok   = (in_row_reg >= RW'(2)) || ((in_row_reg == RW'(1)) && (in_col_reg != '0));
    assign do_store = accept && (in_data.cmd == hmbox_pkg::CMD_SAMPLE) && !in_done;
    assign do_emit  = (do_store && lag_ok)
                   || (accept && (in_data.cmd == hmbox_pkg::CMD_FLUSH) && in_done
                       && (out_row_reg < nrows));
    assign restart  = cfg_we && ((cfg_index == hmbox_pkg::CFG_ROWS)
                              || (cfg_index == hmbox_pkg::CFG_COLS));

    assign in_col_p1 = {1'b0, in_col_reg} + (CW + 1)'(1);
    assign co_p1     = {1'b0, out_col_reg} + (CW + 1)'(1);
    assign ro_p1     = out_row_reg + RW'(1);

    // neighbourhood bounds of the output cell
    assign up_ok  = (out_row_reg != '0);
    assign dn_ok  = (ro_p1 < nrows);
    assign lft_ok = (out_col_reg != '0);
    assign rgt_ok = (co_p1 < ncols);
    assign rv     = 2'd1 + 2'(up_ok) + 2'(dn_ok);
    assign cv     = 2'd1 + 2'(lft_ok) + 2'(rgt_ok);
    assign last   = !dn_ok && !rgt_ok;

    assign load = (state_reg == ST_WAIT) && norm_rsp.done && (!out_valid_reg || !out_stall);

    always_comb
    begin
        raddr_a = out_col_reg - CW'(1);
        raddr_b = co_p1[CW-1:0];
        if (state_reg == ST_RD1)
        begin
            raddr_a = out_col_reg;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        sum_next   = sum_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (do_emit)
                begin
                    state_next = ST_RD0;
                end
            end
            ST_RD0:
            begin
                state_next = ST_RD1;
            end
            ST_RD1:
            begin
                sum_next = SW'(lft_ok ? col_sum(rdata_a, out_row_reg[1:0], up_ok, dn_ok) : 10'd0)
                         + SW'(rgt_ok ? col_sum(rdata_b, out_row_reg[1:0], up_ok, dn_ok) : 10'd0);
                state_next = ST_RD2;
            end
            ST_RD2:
            begin
                state_next = ST_WAIT;
            end
            ST_WAIT:
            begin
                if (load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        norm_req.start = (state_reg == ST_RD2);
        norm_req.ack   = load;
        norm_req.sum   = sum_reg + SW'(col_sum(rdata_a, out_row_reg[1:0], up_ok, dn_ok));
        norm_req.rdiv  = rv;
        norm_req.cdiv  = cv;
    end

    // frame counters
    always_comb
    begin
        in_row_next  = in_row_reg;
        in_col_next  = in_col_reg;
        out_row_next = out_row_reg;
        out_col_next = out_col_reg;
        if (restart || (load && last))
        begin
            in_row_next  = '0;
            in_col_next  = '0;
            out_row_next = '0;
            out_col_next = '0;
        end
        else if (do_store)
        begin
            if (in_col_p1 >= ncols)
            begin
                in_col_next = '0;
                in_row_next = in_row_reg + RW'(1);
            end
            else
            begin
                in_col_next = in_col_p1[CW-1:0];
            end
        end
        else if (load)
        begin
            if (!rgt_ok)
            begin
                out_col_next = '0;
                out_row_next = ro_p1;
            end
            else
            begin
                out_col_next = co_p1[CW-1:0];
            end
        end
    end

    // output register
    always_comb
    begin
        out_valid_next = out_valid_reg && out_stall;
        out_data_next  = out_data_reg;
        if (load)
        begin
            out_valid_next           = 1'b1;
            out_data_next.height     = norm_rsp.height;
            out_data_next.out_row    = ORW'(out_row_reg);
            out_data_next.out_col    = OCW'(out_col_reg);
            out_data_next.frame_last = last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            in_row_reg    <= '0;
            in_col_reg    <= '0;
            out_row_reg   <= '0;
            out_col_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            in_row_reg    <= in_row_next;
            in_col_reg    <= in_col_next;
            out_row_reg   <= out_row_next;
            out_col_reg   <= out_col_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sum_reg      <= sum_next;
        out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    hmbox_line_mem #(
        .MAX_COLS (MAX_COLS)
    ) u_line_mem (
        .clk     (clk),
        .we      (do_store),
        .waddr   (in_col_reg),
        .wlane   (in_row_reg[1:0]),
        .wdata   (in_data.raw_height),
        .raddr_a (raddr_a),
        .raddr_b (raddr_b),
        .rdata_a (rdata_a),
        .rdata_b (rdata_b)
    );

    hmbox_norm u_norm (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (norm_req),
        .scale  ($signed(scale_reg)),
        .offset ($signed(offset_reg)),
        .rsp    (norm_rsp)
    );

endmodule

>>> tb/heightmap_scale_box_filter_3x3_top_tb.sv
// Self-checking testbench for heightmap_scale_box_filter_3x3_top: 3x3 box mean,
// scale and offset of a raster height stream, checked against a cycle-free predictor.
// Depends on hmbox_pkg and the top level of the block; nothing else.
`timescale 1ns / 1ps

module heightmap_scale_box_filter_3x3_top_tb;
    import hmbox_pkg::*;

    localparam int CYCLE_LIMIT   = 500000;
    localparam int TOTAL_ITEMS   = 1400;
    localparam int SETTLE_CYCLES = 16;
    localparam int DRAIN_LIMIT   = 20000;
    localparam int REPORT_MAX    = 10;

    typedef struct {
        in_t         req;
        int unsigned gap;
        bit          drain_first;
    } pending_req_t;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    logic                  in_stall;
    in_t                   in_data   = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    out_t                  out_data;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = CFG_ROWS;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    pending_req_t req_fifo[$];
    out_t         due_cells[$];
    out_t         head_cell;

    // predictor state
    logic [7:0]                     seen_bytes [4][MAX_COLS_DEF];
    int unsigned                    feed_row, feed_col, emit_row, emit_col;
    logic [ROWS_REG_W-1:0]          grid_rows_m;
    logic [COLS_REG_W-1:0]          grid_cols_m;
    logic signed [SCALE_REG_W-1:0]  scale_m;
    logic signed [OFFSET_REG_W-1:0] offset_m;

    int unsigned req_issued    = 0;
    int unsigned req_accepted  = 0;
    int unsigned results_seen  = 0;
    int unsigned results_noted = 0;
    int unsigned results_checked = 0;
    int unsigned errors        = 0;
    int unsigned gap_count     = 0;
    int unsigned rx_wait       = 0;
    int unsigned random_count  = 0;
    int unsigned phases        = 0;
    int unsigned cycle_count   = 0;
    bit          tx_idle_on    = 1'b1;
    bit          rx_idle_on    = 1'b1;

    heightmap_scale_box_filter_3x3_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    function automatic void note_error(string msg);
        errors++;
        if (errors <= REPORT_MAX)
            $display("ERROR: %s", msg);
    endfunction

    function automatic int unsigned rows_in_use();
        if (grid_rows_m == 0)
            return 1;
        if (grid_rows_m > MAX_ROWS_DEF)
            return MAX_ROWS_DEF;
        return grid_rows_m;
    endfunction

    function automatic int unsigned cols_in_use();
        if (grid_cols_m == 0)
            return 1;
        if (grid_cols_m > MAX_COLS_DEF)
            return MAX_COLS_DEF;
        return grid_cols_m;
    endfunction

    function automatic void frame_restart();
        feed_row = 0;
        feed_col = 0;
        emit_row = 0;
        emit_col = 0;
    endfunction

    function automatic void model_reset();
        grid_rows_m = ROWS_RST;
        grid_cols_m = COLS_RST;
        scale_m     = SCALE_RST;
        offset_m    = OFFSET_RST;
        foreach (seen_bytes[i, j])
            seen_bytes[i][j] = 8'h00;
        frame_restart();
    endfunction

    task automatic produce_cell(int unsigned nrows, int unsigned ncols);
        out_t        exp_out;
        int unsigned sum, cnt;
        int          r, c;
        longint      mean_q8, scaled;
        sum = 0;
        cnt = 0;
        for (r = int'(emit_row) - 1; r <= int'(emit_row) + 1; r++)
            for (c = int'(emit_col) - 1; c <= int'(emit_col) + 1; c++)
                if (r >= 0 && r < int'(nrows) && c >= 0 && c < int'(ncols))
                begin
                    sum += seen_bytes[r % 4][c % MAX_COLS_DEF];
                    cnt++;
                end
        mean_q8 = longint'((sum * 256) / cnt);
        // arithmetic shift floors toward minus infinity
        scaled = (mean_q8 * longint'(scale_m)) >>> 8;
        scaled = scaled + longint'(offset_m);
        exp_out.height     = scaled[HEIGHT_W-1:0];
        exp_out.out_row    = emit_row[OUT_ROW_W-1:0];
        exp_out.out_col    = emit_col[OUT_COL_W-1:0];
        exp_out.frame_last = (emit_row + 1 >= nrows) && (emit_col + 1 >= ncols);
        due_cells.push_back(exp_out);
        if (exp_out.frame_last)
            frame_restart();
        else
        begin
            emit_col++;
            if (emit_col >= ncols)
            begin
                emit_col = 0;
                emit_row++;
            end
        end
    endtask

    task automatic advance_filter(in_t req);
        int unsigned nrows, ncols, ri, ci;
        nrows = rows_in_use();
        ncols = cols_in_use();
        if (req.cmd == CMD_FLUSH)
        begin
            if (feed_row >= nrows && emit_row < nrows)
                produce_cell(nrows, ncols);
        end
        else if (feed_row < nrows)
        begin
            ri = feed_row;
            ci = feed_col;
            seen_bytes[ri % 4][ci % MAX_COLS_DEF] = req.raw_height;
            feed_col++;
            if (feed_col >= ncols)
            begin
                feed_col = 0;
                feed_row++;
            end
            if (ri * ncols + ci >= ncols + 1)
                produce_cell(nrows, ncols);
        end
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_ROWS:
            begin
                grid_rows_m = val[ROWS_REG_W-1:0];
                frame_restart();
            end
            CFG_COLS:
            begin
                grid_cols_m = val[COLS_REG_W-1:0];
                frame_restart();
            end
            CFG_SCALE:  scale_m  = val[SCALE_REG_W-1:0];
            CFG_OFFSET: offset_m = val[OFFSET_REG_W-1:0];
            default: ;
        endcase
    endtask

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 7))
            0: return 8'h00;
            1: return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [SCALE_REG_W-1:0] pick_scale();
        case ($urandom_range(0, 7))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'h0100;
            3: return 16'hFFFF;
            default: return SCALE_REG_W'($urandom_range(0, 65535));
        endcase
    endfunction

    function automatic logic [OFFSET_REG_W-1:0] pick_offset();
        case ($urandom_range(0, 5))
            0: return 24'h800000;
            1: return 24'h7FFFFF;
            2: return 24'h000000;
            default: return OFFSET_REG_W'($urandom_range(0, 24'hFFFFFF));
        endcase
    endfunction

    function automatic void queue_req(logic cmd, logic [7:0] val, bit counted, bit hold);
        pending_req_t r;
        r.req.cmd        = cmd;
        r.req.raw_height = val;
        r.gap            = tx_idle_on ? $urandom_range(0, 9) : 0;
        r.drain_first    = hold || ($urandom_range(0, 59) == 0);
        req_fifo.push_back(r);
        if (counted)
            random_count++;
    endfunction

    task automatic queue_frame(int unsigned nr, int unsigned nc, bit broken);
        int unsigned cells, n_samp, n_drain, k;
        cells   = nr * nc;
        n_drain = (cells < nc + 1) ? cells : nc + 1;
        if (!broken)
            n_samp = cells;
        else if (cells > 64)
            n_samp = $urandom_range(nc + 2, 8 * nc);
        else
            n_samp = $urandom_range(0, cells - 1);
        for (k = 0; k < n_samp; k++)
        begin
            if ($urandom_range(0, 11) == 0)
                queue_req(CMD_FLUSH, pick_byte(), 1'b0, 1'b0);   // early flush
            queue_req(CMD_SAMPLE, pick_byte(), 1'b1, 1'b0);
        end
        if (broken)
        begin
            if ($urandom_range(0, 1) != 0)
                repeat ($urandom_range(1, 3))
                    queue_req(CMD_FLUSH, pick_byte(), 1'b0, 1'b0);
        end
        else
        begin
            for (k = 0; k < n_drain; k++)
            begin
                if ($urandom_range(0, 9) == 0)
                    queue_req(CMD_SAMPLE, pick_byte(), 1'b0, 1'b0);  // past end of grid
                queue_req(CMD_FLUSH, pick_byte(), 1'b1, 1'b0);
            end
            if ($urandom_range(0, 3) == 0)
                queue_req(CMD_FLUSH, pick_byte(), 1'b0, 1'b0);
        end
    endtask

    task automatic settle();
        int unsigned spins;
        spins = 0;
        while (req_fifo.size() != 0 || req_accepted != req_issued)
            @(negedge clk);
        while (due_cells.size() != 0 && spins < DRAIN_LIMIT)
        begin
            @(negedge clk);
            spins++;
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // request driver
    always @(negedge clk)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else if (req_accepted == req_issued)
        begin
            if (req_fifo.size() != 0 && gap_count < req_fifo[0].gap)
            begin
                gap_count++;
                in_valid <= 1'b0;
            end
            else if (req_fifo.size() != 0 &&
                     (!req_fifo[0].drain_first || due_cells.size() == 0))
            begin
                in_data  <= req_fifo[0].req;
                in_valid <= 1'b1;
                req_issued++;
                gap_count = 0;
                void'(req_fifo.pop_front());
            end
            else
                in_valid <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && in_valid && !in_stall)
        begin
            advance_filter(in_data);
            req_accepted++;
        end
    end

    // result stall generator
    always @(negedge clk)
    begin
        if (results_seen != results_noted)
        begin
            results_noted = results_seen;
            rx_wait = rx_idle_on ? $urandom_range(0, 9) : 0;
        end
        else if (rx_wait != 0)
            rx_wait--;
        out_stall <= (rx_wait != 0);
    end

    // result monitor
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            results_seen++;
            if (due_cells.size() == 0)
                note_error($sformatf("unexpected result h=%0d row=%0d col=%0d last=%0b",
                    out_data.height, out_data.out_row, out_data.out_col,
                    out_data.frame_last));
            else
            begin
                head_cell = due_cells.pop_front();
                results_checked++;
                if (out_data.height !== head_cell.height ||
                    out_data.out_row !== head_cell.out_row ||
                    out_data.out_col !== head_cell.out_col ||
                    out_data.frame_last !== head_cell.frame_last)
                    note_error($sformatf(
                        "result %0d: exp h=%0d r=%0d c=%0d l=%0b, got h=%0d r=%0d c=%0d l=%0b",
                        results_checked, head_cell.height, head_cell.out_row,
                        head_cell.out_col, head_cell.frame_last, out_data.height,
                        out_data.out_row, out_data.out_col, out_data.frame_last));
            end
        end
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles", cycle_count);
        $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        int unsigned rows_w, cols_w, nr, nc, nframes, sel, f;
        bit          broken;
        logic [7:0]  junk;

        model_reset();
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;

        // 3x3 grid at the largest scale and offset: corners, edges, center,
        // early flush, sample past the grid, flush after frame end
        write_reg(CFG_ROWS, 3);
        write_reg(CFG_COLS, 3);
        write_reg(CFG_SCALE, 16'h7FFF);
        write_reg(CFG_OFFSET, 24'h7FFFFF);
        queue_req(CMD_SAMPLE, 8'hFF, 1'b0, 1'b0);
        queue_req(CMD_FLUSH, 8'h00, 1'b0, 1'b0);
        queue_req(CMD_SAMPLE, 8'h00, 1'b0, 1'b0);
        queue_req(CMD_SAMPLE, 8'hAA, 1'b0, 1'b0);
        queue_req(CMD_SAMPLE, 8'h55, 1'b0, 1'b0);
        queue_req(CMD_SAMPLE, 8'hFF, 1'b0, 1'b0);
        queue_req(CMD_SAMPLE, 8'h01, 1'b0, 1'b0);
        queue_req(CMD_SAMPLE, 8'h80, 1'b0, 1'b0);
        queue_req(CMD_SAMPLE, 8'hFE, 1'b0, 1'b0);
        queue_req(CMD_SAMPLE, 8'h7F, 1'b0, 1'b0);
        queue_req(CMD_FLUSH, 8'hFF, 1'b0, 1'b0);
        queue_req(CMD_SAMPLE, 8'h4D, 1'b0, 1'b0);
        repeat (3) queue_req(CMD_FLUSH, 8'h00, 1'b0, 1'b0);
        queue_req(CMD_FLUSH, 8'hFF, 1'b0, 1'b0);
        settle();

        // zero sizes clamp to a 1x1 grid; most negative scale and offset
        write_reg(CFG_ROWS, 0);
        write_reg(CFG_COLS, 0);
        write_reg(CFG_SCALE, 16'h8000);
        write_reg(CFG_OFFSET, 24'h800000);
        queue_req(CMD_SAMPLE, 8'hFF, 1'b0, 1'b1);
        queue_req(CMD_FLUSH, 8'h00, 1'b0, 1'b0);
        settle();

        // single row: divide by 2 and 3
        write_reg(CFG_ROWS, 1);
        write_reg(CFG_COLS, 3);
        queue_req(CMD_SAMPLE, 8'h09, 1'b0, 1'b0);
        queue_req(CMD_SAMPLE, 8'hC8, 1'b0, 1'b0);
        queue_req(CMD_SAMPLE, 8'h1F, 1'b0, 1'b0);
        repeat (3) queue_req(CMD_FLUSH, 8'hFF, 1'b0, 1'b0);
        settle();
        phases = 3;

        // oversized registers clamp to the full line width and row count
        tx_idle_on = ($urandom_range(0, 1) != 0);
        write_reg(CFG_ROWS, 8191);
        write_reg(CFG_COLS, 2047);
        repeat (MAX_COLS_DEF + 6) queue_req(CMD_SAMPLE, pick_byte(), 1'b0, 1'b0);
        settle();
        phases++;

        while (req_issued < TOTAL_ITEMS)
        begin
            tx_idle_on = ($urandom_range(0, 3) != 0);
            rx_idle_on = ($urandom_range(0, 3) != 0);
            rows_w = $urandom_range(1, 6);
            cols_w = $urandom_range(1, 8);
            sel    = $urandom_range(0, 15);
            if (sel == 0)
                rows_w = 0;
            else if (sel == 1)
                rows_w = $urandom_range(MAX_ROWS_DEF, 8191);
            else if (sel == 2)
                cols_w = 0;
            if ($urandom_range(0, 1) != 0)
            begin
                write_reg(CFG_ROWS, CFG_DATA_W'(rows_w));
                write_reg(CFG_COLS, CFG_DATA_W'(cols_w));
            end
            else
            begin
                write_reg(CFG_COLS, CFG_DATA_W'(cols_w));
                write_reg(CFG_ROWS, CFG_DATA_W'(rows_w));
            end
            if ($urandom_range(0, 1) != 0)
            begin
                junk = 8'($urandom_range(0, 255));
                write_reg(CFG_SCALE, {junk, pick_scale()});
            end
            if ($urandom_range(0, 1) != 0)
                write_reg(CFG_OFFSET, pick_offset());
            nr = rows_in_use();
            nc = cols_in_use();
            nframes = $urandom_range(1, 3);
            for (f = 0; f < nframes; f++)
            begin
                broken = (nr * nc > 64) || ($urandom_range(0, 5) == 0);
                queue_frame(nr, nc, broken);
                if (broken)
                    break;
            end
            phases++;
            settle();
        end

        settle();
        if (due_cells.size() != 0)
            note_error($sformatf("%0d expected results never arrived", due_cells.size()));
        $display("checked %0d results from %0d requests (%0d random) over %0d configs, %0d errors",
            results_checked, req_accepted, random_count, phases, errors);
        $display("grids 1x1 up to 4096x1024 incl. clamped sizes; early, idle and drain flushes");
        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
